>>> src/sts_pkg.sv
package sts_pkg;

    // Fixed field widths
    localparam int IDX_W     = 12;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;

    // Default table size
    localparam int TABLE_DEPTH_DEF = 4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX  = 2'd2;

    // Input item actions
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Search modes
    localparam logic MODE_BINARY = 1'b0;
    localparam logic MODE_LINEAR = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FINISH
    } state_t;

endpackage

>>> src/sorted_table_search_unit.sv
// Load beat: no result; the next beat may follow at once.
// Search beat: on acceptance the key is taken and the first read issued, then each table
// probe is compared right behind the single RAM read port until a hit or an empty range;
// binary mode needs at most floor(log2(range))+1 probes (13 at 4096).
// The result lands in an output register; a stalled result holds it in a spare register.
// Reset (rst_n, async, active low) clears control and config; table is undefined until written.
module sorted_table_search_unit
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // config write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    // input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic signed [WORD_W-1:0] word,
    // output channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     found,
    output logic [IDX_W-1:0]         position
);

    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int SW        = IDX_W + 2;
    localparam int LIMIT_INT = (TABLE_DEPTH > (1 << IDX_W)) ? (1 << IDX_W) - 1
                                                            : TABLE_DEPTH - 1;
    localparam logic [IDX_W-1:0] LAST_LIMIT = IDX_W'(LIMIT_INT);

    // Configuration registers
    logic             search_mode_reg;
    logic [IDX_W-1:0] first_index_reg;
    logic [IDX_W-1:0] last_index_reg;

    // Search state
    state_t                   state_reg, state_next;
    logic signed [SW-1:0]     low_reg, high_reg;
    logic [IDX_W-1:0]         probe_reg;
    logic [WORD_W-1:0]        key_reg;
    logic                     hold_found_reg;
    logic [IDX_W-1:0]         hold_pos_reg;

    // Output register
    logic                     out_valid_reg;
    logic                     found_reg;
    logic [IDX_W-1:0]         position_reg;

    // Combinational
    logic [WORD_W-1:0]        rdata;
    logic                     key_eq, key_lt;
    logic [IDX_W-1:0]         high_clamp;
    logic signed [SW-1:0]     probe_ext;
    logic signed [SW-1:0]     step_low, step_high;
    logic signed [SW-1:0]     rng_low, rng_high, mid_sum;
    logic                     rng_empty;
    logic [IDX_W-1:0]         next_probe;
    logic                     search_start, load_write, issue_probe;
    logic                     res_done, res_found;
    logic [IDX_W-1:0]         res_pos;
    logic                     slot_free, out_load;

    // Table memory
    sts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_write),
        .waddr (ADDR_W'(entry_index)),
        .wdata (word),
        .raddr (ADDR_W'(next_probe)),
        .rdata (rdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_mode_reg <= MODE_BINARY;
            first_index_reg <= '0;
            last_index_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEARCH_MODE: search_mode_reg <= cfg_wdata[0];
                CFG_FIRST_INDEX: first_index_reg <= cfg_wdata[IDX_W-1:0];
                CFG_LAST_INDEX:  last_index_reg  <= cfg_wdata[IDX_W-1:0];
                default:         ;
            endcase
        end
    end

    // Compare the probed entry and narrow the range
    always_comb
    begin
        key_eq     = (rdata == key_reg);
        key_lt     = ($signed(key_reg) < $signed(rdata));
        high_clamp = (last_index_reg > LAST_LIMIT) ? LAST_LIMIT : last_index_reg;
        probe_ext  = $signed({2'b00, probe_reg});
        step_low   = low_reg;
        step_high  = high_reg;
        if (search_mode_reg == MODE_BINARY && key_lt)
        begin
            step_high = probe_ext - SW'(1);
        end
        else
        begin
            step_low = probe_ext + SW'(1);
        end
        if (state_reg == ST_IDLE)
        begin
            rng_low  = $signed({2'b00, first_index_reg});
            rng_high = $signed({2'b00, high_clamp});
        end
        else
        begin
            rng_low  = step_low;
            rng_high = step_high;
        end
        rng_empty  = (rng_low > rng_high);
        mid_sum    = rng_low + rng_high;
        next_probe = (search_mode_reg == MODE_BINARY) ? mid_sum[IDX_W:1]
                                                      : rng_low[IDX_W-1:0];
    end

    // Handshake, table write, probe issue and result
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        search_start = in_valid && in_ready && (action == ACT_SEARCH);
        load_write   = in_valid && in_ready && (action == ACT_LOAD)
                       && (entry_index <= LAST_LIMIT);
        slot_free    = !out_valid_reg || out_ready;
        res_done     = 1'b0;
        res_found    = 1'b0;
        res_pos      = '0;
        issue_probe  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (search_start)
                begin
                    res_done    = rng_empty;
                    issue_probe = !rng_empty;
                end
            end
            ST_PROBE:
            begin
                if (key_eq)
                begin
                    res_done  = 1'b1;
                    res_found = 1'b1;
                    res_pos   = probe_reg;
                end
                else if (rng_empty)
                begin
                    res_done = 1'b1;
                end
                else
                begin
                    issue_probe = 1'b1;
                end
            end
            ST_FINISH: ;
            default: ;
        endcase
        out_load = slot_free && (res_done || state_reg == ST_FINISH);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (search_start)
                begin
                    if (!rng_empty)
                    begin
                        state_next = ST_PROBE;
                    end
                    else if (!slot_free)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_PROBE:
            begin
                if (res_done)
                begin
                    state_next = slot_free ? ST_IDLE : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (search_start)
        begin
            key_reg <= word;
        end
        if (issue_probe)
        begin
            low_reg   <= rng_low;
            high_reg  <= rng_high;
            probe_reg <= next_probe;
        end
        if (res_done)
        begin
            hold_found_reg <= res_found;
            hold_pos_reg   <= res_pos;
        end
        if (out_load)
        begin
            if (state_reg == ST_FINISH)
            begin
                found_reg    <= hold_found_reg;
                position_reg <= hold_pos_reg;
            end
            else
            begin
                found_reg    <= res_found;
                position_reg <= res_pos;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    // Probe stays inside the live range and the table
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |->
            low_reg <= probe_ext && probe_ext <= high_reg && probe_reg <= LAST_LIMIT)
        else $error("probe outside search range");

    // A miss reports position zero
    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> position_reg == '0)
        else $error("miss with nonzero position");

    // A hit lies within the configured range
    a_hit_in_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_reg |->
            position_reg >= first_index_reg && position_reg <= last_index_reg)
        else $error("hit outside configured range");

    // Parking a result only happens behind a stalled output
    a_finish_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && $past(state_reg) != ST_FINISH |->
            $past(out_valid_reg) && !$past(out_ready))
        else $error("result parked while output was free");

    // No table write outside idle
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_write |-> state_reg == ST_IDLE && !issue_probe)
        else $error("table write during a search");

endmodule

>>> src/sts_ram.sv
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> tb/sv/sorted_table_search_unit_tb.sv
module sorted_table_search_unit_tb;
    import sts_pkg::*;

    localparam int DEPTH         = TABLE_DEPTH_DEF;
    localparam int ITEM_TARGET   = 1750;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } search_answer_t;

    typedef struct {
        bit               is_cfg;
        logic             act;
        logic [IDX_W-1:0] idx;
        logic [WORD_W-1:0] w;
        bit               typed;
        logic             ef;
        logic [IDX_W-1:0] ep;
        logic             mode;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
    } plan_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_wdata = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     action = ACT_LOAD;
    logic [IDX_W-1:0]         entry_index = '0;
    logic signed [WORD_W-1:0] word = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     found;
    logic [IDX_W-1:0]         position;

    // shadow copy of the table and the registers
    bit signed [WORD_W-1:0] shadow_words [DEPTH];
    bit                     word_written [DEPTH];
    logic                   cur_mode = MODE_BINARY;
    logic [IDX_W-1:0]       cur_first = '0;
    logic [IDX_W-1:0]       cur_last = '0;

    search_answer_t pending_answers [$];
    plan_row_t      plan_rows [$];
    int             beats_taken = 0;
    int             mismatches = 0;
    int             cycles = 0;
    logic           quiet = 1'b0;
    logic           hold_off = 1'b0;

    sorted_table_search_unit #(.TABLE_DEPTH(DEPTH)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .entry_index(entry_index),
        .word(word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .found(found),
        .position(position)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("mismatch: %s expected %0d got %0d (beat %0d)", what, exp_val, got_val,
                 beats_taken);
        mismatches++;
    endtask

    // Compute the answer of a search under the current registers.
    // Returns 0 when the search would touch an entry never loaded.
    function automatic bit predict_lookup(input logic signed [WORD_W-1:0] key,
                                          output logic hit, output logic [IDX_W-1:0] pos);
        int lo;
        int hi;
        int mid;
        int i;
        bit legal;
        lo = cur_first;
        hi = cur_last;
        hit = 1'b0;
        pos = '0;
        legal = 1'b1;
        if (hi > DEPTH - 1)
            hi = DEPTH - 1;
        if (cur_mode == MODE_BINARY)
        begin
            while (lo <= hi && !hit && legal)
            begin
                mid = (lo + hi) / 2;
                if (!word_written[mid])
                    legal = 1'b0;
                else if (key == shadow_words[mid])
                begin
                    hit = 1'b1;
                    pos = mid[IDX_W-1:0];
                end
                else if (key < shadow_words[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        else
        begin
            for (i = lo; i <= hi && !hit && legal; i++)
            begin
                if (!word_written[i])
                    legal = 1'b0;
                else if (shadow_words[i] == key)
                begin
                    hit = 1'b1;
                    pos = i[IDX_W-1:0];
                end
            end
        end
        return legal;
    endfunction

    // Offer one beat, wait for it to be taken, then update the shadow state.
    // Valid is left high; the next call or the caller lowers it.
    task automatic send_beat(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] w, input bit typed,
                             input logic ef, input logic [IDX_W-1:0] ep);
        search_answer_t ans;
        logic h;
        logic [IDX_W-1:0] p;
        while (!quiet && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        entry_index <= idx;
        word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        beats_taken++;
        quiet <= (beats_taken >= 700 && beats_taken < 950);
        if (act == ACT_LOAD)
        begin
            if (idx < DEPTH)
            begin
                shadow_words[idx] = w;
                word_written[idx] = 1'b1;
            end
        end
        else
        begin
            void'(predict_lookup(w, h, p));
            if (typed)
            begin
                ans.found = ef;
                ans.position = ep;
            end
            else
            begin
                ans.found = h;
                ans.position = p;
            end
            pending_answers.push_back(ans);
        end
    endtask

    // Drain, let the block settle, then write all three registers.
    task automatic set_config(input logic m, input logic [IDX_W-1:0] f,
                              input logic [IDX_W-1:0] l);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SEARCH_MODE;
        cfg_wdata <= {{(CFG_W-1){1'b0}}, m};
        @(posedge clk);
        cfg_index <= CFG_FIRST_INDEX;
        cfg_wdata <= f;
        @(posedge clk);
        cfg_index <= CFG_LAST_INDEX;
        cfg_wdata <= l;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode = m;
        cur_first = f;
        cur_last = l;
    endtask

    task automatic add_load(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] w);
        plan_row_t r;
        r = '{default: '0};
        r.act = ACT_LOAD;
        r.idx = idx;
        r.w = w;
        plan_rows.push_back(r);
    endtask

    task automatic add_search(input logic [WORD_W-1:0] key, input bit typed,
                              input logic ef, input logic [IDX_W-1:0] ep);
        plan_row_t r;
        r = '{default: '0};
        r.act = ACT_SEARCH;
        r.idx = 12'($urandom_range(DEPTH - 1));
        r.w = key;
        r.typed = typed;
        r.ef = ef;
        r.ep = ep;
        plan_rows.push_back(r);
    endtask

    task automatic add_cfg(input logic m, input logic [IDX_W-1:0] f,
                           input logic [IDX_W-1:0] l);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.mode = m;
        r.first = f;
        r.last = l;
        plan_rows.push_back(r);
    endtask

    task automatic send_noise_load();
        send_beat(ACT_LOAD, 12'($urandom_range(DEPTH - 1)), $urandom, 1'b0, 1'b0, '0);
    endtask

    // One random phase: place a window, pick a range, fill the window, search it.
    task automatic run_phase();
        int size;
        int base;
        int first;
        int last;
        int n;
        int i;
        int t;
        int r;
        bit sorted_fill;
        bit legal;
        longint cur;
        logic m;
        logic h;
        logic [IDX_W-1:0] p;
        logic [WORD_W-1:0] key;
        r = $urandom_range(99);
        if (r < 70)
            size = $urandom_range(1, 12);
        else if (r < 92)
            size = $urandom_range(13, 40);
        else
            size = $urandom_range(41, 64);
        r = $urandom_range(99);
        if (r < 10)
            base = 0;
        else if (r < 20)
            base = DEPTH - size;
        else
            base = $urandom_range(0, DEPTH - size);
        m = 1'($urandom_range(1));
        r = $urandom_range(99);
        if (r < 75)
        begin
            first = base;
            last = base + size - 1;
        end
        else if (r < 83)
        begin
            first = base + $urandom_range(0, size - 1);
            last = $urandom_range(first, base + size - 1);
        end
        else if (r < 88)
        begin
            first = $urandom_range(1, DEPTH - 1);
            last = $urandom_range(0, first - 1);
        end
        else if (r < 93)
        begin
            first = 0;
            last = DEPTH - 1;
        end
        else
        begin
            first = base;
            last = base + size - 1 + $urandom_range(1, 8);
            if (last > DEPTH - 1)
                last = DEPTH - 1;
        end
        set_config(m, first[IDX_W-1:0], last[IDX_W-1:0]);

        // fill the window, mostly ascending with some repeats
        sorted_fill = ($urandom_range(99) < 80);
        if ($urandom_range(99) < 12)
            cur = -64'sd2147483648;
        else
            cur = longint'(int'($urandom)) >>> $urandom_range(0, 8);
        for (i = 0; i < size; i++)
        begin
            if ($urandom_range(99) < 6)
                send_noise_load();
            send_beat(ACT_LOAD, 12'(base + i), sorted_fill ? cur[WORD_W-1:0] : $urandom,
                      1'b0, 1'b0, '0);
            r = $urandom_range(99);
            if (r < 15)
                cur = cur;
            else if (r < 85)
                cur = cur + $urandom_range(1, 50);
            else
                cur = cur + $urandom_range(1, 32'h0fff_ffff);
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
        end

        // search with keys drawn mostly from the window
        n = 2 * size + $urandom_range(2, 8);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
                send_noise_load();
            legal = 1'b0;
            for (t = 0; t < 8 && !legal; t++)
            begin
                r = $urandom_range(99);
                if (r < 55)
                    key = shadow_words[base + $urandom_range(0, size - 1)];
                else if (r < 70)
                    key = shadow_words[base + $urandom_range(0, size - 1)]
                          + ($urandom_range(1) ? 32'd1 : 32'hffff_ffff);
                else if (r < 85)
                    key = $urandom;
                else if (r < 92)
                    key = WORD_MIN;
                else
                    key = WORD_MAX;
                legal = predict_lookup(key, h, p);
            end
            if (legal)
                send_beat(ACT_SEARCH, 12'($urandom_range(DEPTH - 1)), key, 1'b0, 1'b0, '0);
        end
    endtask

    // Result side: check each taken beat, then pick next ready.
    always @(posedge clk)
    begin
        search_answer_t due;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch("result with no search pending", 0, 1);
                else
                begin
                    due = pending_answers.pop_front();
                    if (found !== due.found)
                        report_mismatch("found", due.found, found);
                    if (position !== due.position)
                        report_mismatch("position", due.position, position);
                end
            end
            out_ready <= !hold_off && (quiet || $urandom_range(99) >= 24);
        end
    end

    // Long receiver hold-offs so the block backs up into its input.
    initial
    begin
        int k;
        for (k = 0; k < 2; k++)
        begin
            wait (beats_taken >= 300 + 900 * k);
            @(posedge clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // Watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus
    initial
    begin
        int k;
        plan_row_t row;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan: registers start at binary mode over entry zero
        add_load(12'd0, WORD_MIN);
        add_search(WORD_MIN, 1'b1, 1'b1, 12'd0);
        add_search(WORD_MAX, 1'b1, 1'b0, 12'd0);
        add_load(12'd4095, WORD_MAX);
        add_load(12'd1, 32'hffff_fffb);
        add_load(12'd2, 32'd0);
        add_load(12'd3, 32'd7);
        // empty range
        add_cfg(MODE_BINARY, 12'd4, 12'd3);
        add_search(32'd0, 1'b1, 1'b0, 12'd0);
        add_cfg(MODE_BINARY, 12'd0, 12'd3);
        add_search(32'd7, 1'b0, 1'b0, '0);
        add_search(32'hffff_fffb, 1'b0, 1'b0, '0);
        add_search(32'd1, 1'b0, 1'b0, '0);
        add_search(WORD_MIN, 1'b0, 1'b0, '0);
        add_search(WORD_MAX, 1'b0, 1'b0, '0);
        // full range, linear, hit on the first entry
        add_cfg(MODE_LINEAR, 12'd0, 12'd4095);
        add_search(WORD_MIN, 1'b1, 1'b1, 12'd0);
        add_cfg(MODE_LINEAR, 12'd4095, 12'd4095);
        add_search(WORD_MAX, 1'b1, 1'b1, 12'd4095);
        add_search(32'd0, 1'b1, 1'b0, 12'd0);
        // unsorted table with a repeated value
        add_load(12'd1, 32'd100);
        add_load(12'd3, 32'd0);
        add_cfg(MODE_BINARY, 12'd0, 12'd3);
        add_search(32'd100, 1'b0, 1'b0, '0);
        add_search(32'd0, 1'b0, 1'b0, '0);
        add_cfg(MODE_LINEAR, 12'd0, 12'd3);
        add_search(32'd0, 1'b0, 1'b0, '0);

        for (k = 0; k < plan_rows.size(); k++)
        begin
            row = plan_rows[k];
            if (row.is_cfg)
                set_config(row.mode, row.first, row.last);
            else
                send_beat(row.act, row.idx, row.w, row.typed, row.ef, row.ep);
        end

        while (beats_taken < ITEM_TARGET)
            run_phase();

        // drain and finish
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
